// ===== design/icv_pkg.sv =====
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types and fixed widths of the 2D image convolution block.
// ----------------------------------------------------------------------------
package icv_pkg;

    localparam int KDIM_W     = 4;   // kernel size registers
    localparam int IMG_W_W    = 11;  // image width register
    localparam int IMG_H_W    = 16;  // image height register and row counter
    localparam int CIDX_W     = 7;   // coefficient index register
    localparam int COEF_W     = 16;  // Q2.14 coefficient
    localparam int FRAC_BITS  = 14;
    localparam int RES_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_COLS  = 3'd0,
        CFG_KERNEL_ROWS  = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_IMAGE_HEIGHT = 3'd3,
        CFG_COEF_INDEX   = 3'd4,
        CFG_COEF_VALUE   = 3'd5
    } t_cfg_idx;

endpackage

// ===== design/icv_pix_if.sv =====
// ----------------------------------------------------------------------------
// icv_pix_if
// Pixel input channel: valid/ready handshake with one pixel per transfer.
// ----------------------------------------------------------------------------
interface icv_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

// ===== design/icv_res_if.sv =====
// ----------------------------------------------------------------------------
// icv_res_if
// Result output channel: valid/ready handshake with one result per transfer.
// ----------------------------------------------------------------------------
interface icv_res_if #(
    parameter int COL_W = 10
);
    logic                             valid;
    logic                             ready;
    logic signed [icv_pkg::RES_W-1:0] result_value;
    logic [icv_pkg::IMG_H_W-1:0]      out_row;
    logic [COL_W-1:0]                 out_col;
    logic                             frame_last;

    modport source (output valid, output result_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input result_value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

// ===== design/icv_line_store.sv =====
// ----------------------------------------------------------------------------
// icv_line_store
// One synchronous RAM bank per kernel row. A pixel is written into the bank
// of its row; all banks are read at the same column into output registers.
// ----------------------------------------------------------------------------
module icv_line_store #(
    parameter int BANKS      = 9,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int BANK_W     = 4,
    parameter int COL_W      = 10
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [BANK_W-1:0]            i_wr_bank,
    input  logic [COL_W-1:0]             i_wr_col,
    input  logic signed [PIXEL_BITS-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [COL_W-1:0]             i_rd_col,
    output logic signed [PIXEL_BITS-1:0] o_rd_data [BANKS]
);

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic signed [PIXEL_BITS-1:0] mem [MAX_WIDTH];
        logic signed [PIXEL_BITS-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_bank == BANK_W'(b))) begin
                mem[i_wr_col] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_q <= mem[i_rd_col];
            end
        end

        assign o_rd_data[b] = r_q;
    end

endmodule

// ===== design/image_convolution_2d_top.sv =====
// ----------------------------------------------------------------------------
// image_convolution_2d_top
// Streaming 2D convolution (kernel flipped 180 degrees) over raster pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and gives one result per clock for
// interior centres while the output is not stalled; border positions give
// no result. The last MAX_KERNEL rows sit in one RAM bank per row, all read
// at the current column, so a full column of the neighbourhood arrives in
// the cycle after the pixel and is shifted into a window. Every tap has its
// own multiplier, and the sum goes through a registered two-level adder
// tree. Coefficients are loaded by writing coef_index and then coef_value;
// the user changes configuration only while no pixel is in flight, which
// the block itself does not enforce.
module image_convolution_2d_top #(
    parameter int MAX_KERNEL = 9,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    icv_pix_if.sink                           i_pix,
    icv_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [icv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [icv_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TAPS    = MAX_KERNEL * MAX_KERNEL;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int BANK_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int EXT_W   = ($clog2(MAX_WIDTH + 1) > icv_pkg::IMG_W_W) ?
                             $clog2(MAX_WIDTH + 1) : icv_pkg::IMG_W_W;
    localparam int H_W     = icv_pkg::IMG_H_W;
    localparam int K_W     = icv_pkg::KDIM_W;
    localparam int PROD_W  = PIXEL_BITS + icv_pkg::COEF_W;
    localparam int GROW_W  = $clog2(MAX_KERNEL + 1);
    localparam int RSUM_W  = PROD_W + GROW_W;
    localparam int SUM_W   = RSUM_W + GROW_W;
    localparam int META_W  = H_W + COL_W + 1;

    // Configuration registers and coefficient table
    logic [K_W-1:0]                  r_kcols, r_krows;
    logic [icv_pkg::IMG_W_W-1:0]     r_img_w;
    logic [H_W-1:0]                  r_img_h;
    logic [icv_pkg::CIDX_W-1:0]      r_coef_idx;
    logic signed [icv_pkg::COEF_W-1:0] r_coef [TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kcols    <= K_W'(3);
            r_krows    <= K_W'(3);
            r_img_w    <= icv_pkg::IMG_W_W'(1024);
            r_img_h    <= H_W'(1024);
            r_coef_idx <= '0;
        end else if (i_cfg_we) begin
            case (icv_pkg::t_cfg_idx'(i_cfg_index))
                icv_pkg::CFG_KERNEL_COLS:  r_kcols    <= i_cfg_data[K_W-1:0];
                icv_pkg::CFG_KERNEL_ROWS:  r_krows    <= i_cfg_data[K_W-1:0];
                icv_pkg::CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg_data[icv_pkg::IMG_W_W-1:0];
                icv_pkg::CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg_data[H_W-1:0];
                icv_pkg::CFG_COEF_INDEX:   r_coef_idx <= i_cfg_data[icv_pkg::CIDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < TAPS; t++) begin
            if (i_cfg_we && (icv_pkg::t_cfg_idx'(i_cfg_index) == icv_pkg::CFG_COEF_VALUE)
                && (int'(r_coef_idx) == t)) begin
                r_coef[t] <= $signed(i_cfg_data);
            end
        end
    end

    function automatic logic [K_W-1:0] odd_size(input logic [K_W-1:0] v);
        logic [K_W-1:0] t;
        t = v;
        if (t == '0) t = K_W'(1);
        if (t > K_W'(MAX_KERNEL)) t = K_W'(MAX_KERNEL);
        if (!t[0]) t = t - K_W'(1);
        return t;
    endfunction

    logic [K_W-1:0]   kc, kr;
    logic [EXT_W-1:0] w_eff;
    logic [H_W-1:0]   h_eff;

    always_comb begin
        kc    = odd_size(r_kcols);
        kr    = odd_size(r_krows);
        w_eff = EXT_W'(r_img_w);
        if (w_eff == '0) w_eff = EXT_W'(1);
        if (w_eff > EXT_W'(MAX_WIDTH)) w_eff = EXT_W'(MAX_WIDTH);
        h_eff = (r_img_h == '0) ? H_W'(1) : r_img_h;
    end

    // Pipeline handshake: each stage moves when the next one is empty or moving.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic accept;

    assign rdy6   = !r_v6 || o_res.ready;
    assign rdy5   = !r_v5 || rdy6;
    assign rdy4   = !r_v4 || rdy5;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign i_pix.ready = rdy1;
    assign accept = i_pix.valid && rdy1;

    // Position counters
    logic [COL_W-1:0]  r_col, n_col, cur_c;
    logic [H_W-1:0]    r_row, n_row, cur_r;
    logic [BANK_W-1:0] r_bank, n_bank, cur_bank;
    logic              emit, last;
    logic [EXT_W:0]    c_inc;
    logic [H_W:0]      r_inc;

    always_comb begin
        cur_c    = r_col;
        cur_r    = r_row;
        cur_bank = r_bank;
        if (i_pix.frame_start || (EXT_W'(r_col) >= w_eff) || (r_row >= h_eff)) begin
            cur_c    = '0;
            cur_r    = '0;
            cur_bank = '0;
        end
        emit = (cur_r >= H_W'(kr - K_W'(1))) && (EXT_W'(cur_c) >= EXT_W'(kc - K_W'(1)));
        last = (cur_r == h_eff - H_W'(1)) && (EXT_W'(cur_c) == w_eff - EXT_W'(1));

        c_inc  = {1'b0, EXT_W'(cur_c)} + (EXT_W + 1)'(1);
        r_inc  = {1'b0, cur_r} + (H_W + 1)'(1);
        n_col  = c_inc[COL_W-1:0];
        n_row  = cur_r;
        n_bank = cur_bank;
        if (c_inc >= {1'b0, w_eff}) begin
            n_col = '0;
            if (r_inc >= {1'b0, h_eff}) begin
                n_row  = '0;
                n_bank = '0;
            end else begin
                n_row  = r_inc[H_W-1:0];
                n_bank = (cur_bank == BANK_W'(MAX_KERNEL - 1)) ? '0 : cur_bank + BANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bank <= n_bank;
        end
    end

    // Line store: read the current column of every bank while writing the pixel.
    logic signed [PIXEL_BITS-1:0] ls_q [MAX_KERNEL];

    icv_line_store #(
        .BANKS      (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .BANK_W     (BANK_W),
        .COL_W      (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_bank (cur_bank),
        .i_wr_col  (cur_c),
        .i_wr_data (i_pix.pixel_value),
        .i_rd_en   (accept),
        .i_rd_col  (cur_c),
        .o_rd_data (ls_q)
    );

    // Stage 1: pixel and position wait for the RAM read data.
    logic signed [PIXEL_BITS-1:0] r_px1;
    logic [BANK_W-1:0]            r_bank1;
    logic                         r_emit1;
    logic [META_W-1:0]            r_meta [1:6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1     <= i_pix.pixel_value;
            r_bank1   <= cur_bank;
            r_emit1   <= emit;
            r_meta[1] <= {cur_r - H_W'(kr >> 1), cur_c - COL_W'(kc >> 1), last};
        end
    end

    // Column of the neighbourhood, newest row first. The current row comes
    // from the pixel itself because its bank is written in the same cycle as the read.
    logic signed [PIXEL_BITS-1:0] col_vec [MAX_KERNEL];

    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            if (a == 0) begin
                col_vec[a] = r_px1;
            end else if (r_bank1 >= BANK_W'(a)) begin
                col_vec[a] = ls_q[r_bank1 - BANK_W'(a)];
            end else begin
                col_vec[a] = ls_q[BANK_W'(MAX_KERNEL - a) + r_bank1];
            end
        end
    end

    // Stage 2: window, column 0 is the newest.
    logic signed [PIXEL_BITS-1:0] r_win [MAX_KERNEL][MAX_KERNEL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1 && r_emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            r_meta[2] <= r_meta[1];
            for (int a = 0; a < MAX_KERNEL; a++) begin
                r_win[a][0] <= col_vec[a];
                for (int j = 1; j < MAX_KERNEL; j++) begin
                    r_win[a][j] <= r_win[a][j-1];
                end
            end
        end
    end

    // Coefficient for each tap. With the flip, the tap of row age a and
    // column age j uses kernel entry a * kc + j.
    logic signed [icv_pkg::COEF_W-1:0] coef_lane [MAX_KERNEL][MAX_KERNEL];

    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                coef_lane[a][j] = '0;
                for (int k = 1; k <= MAX_KERNEL; k += 2) begin
                    if ((kc == K_W'(k)) && (j < k) && (K_W'(a) < kr)) begin
                        coef_lane[a][j] = r_coef[a * k + j];
                    end
                end
            end
        end
    end

    // Stage 3: one multiplier per tap.
    logic signed [PROD_W-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    // Taps outside the kernel are forced to zero, because their window data
    // may come from line store rows that were never written.
    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_meta[3] <= r_meta[2];
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int j = 0; j < MAX_KERNEL; j++) begin
                    if ((K_W'(a) < kr) && (K_W'(j) < kc)) begin
                        r_prod[a][j] <= PROD_W'(r_win[a][j] * coef_lane[a][j]);
                    end else begin
                        r_prod[a][j] <= '0;
                    end
                end
            end
        end
    end

    // Stage 4: row sums.
    logic signed [RSUM_W-1:0] r_rsum [MAX_KERNEL];
    logic signed [RSUM_W-1:0] rsum_c [MAX_KERNEL];

    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            rsum_c[a] = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                rsum_c[a] = rsum_c[a] + RSUM_W'(r_prod[a][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            r_meta[4] <= r_meta[3];
            r_rsum    <= rsum_c;
        end
    end

    // Stage 5: total.
    logic signed [SUM_W-1:0] r_sum, sum_c;

    always_comb begin
        sum_c = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            sum_c = sum_c + SUM_W'(r_rsum[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && rdy5) begin
            r_meta[5] <= r_meta[4];
            r_sum     <= sum_c;
        end
    end

    // Stage 6: output register; the arithmetic shift floors toward minus infinity.
    logic signed [SUM_W-1:0]          sum_shr;
    logic signed [icv_pkg::RES_W-1:0] r_res;

    assign sum_shr = r_sum >>> icv_pkg::FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (rdy6) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && rdy6) begin
            r_meta[6] <= r_meta[5];
            r_res     <= sum_shr[icv_pkg::RES_W-1:0];
        end
    end

    assign o_res.valid        = r_v6;
    assign o_res.result_value = r_res;
    assign o_res.out_row      = r_meta[6][META_W-1 -: H_W];
    assign o_res.out_col      = r_meta[6][COL_W:1];
    assign o_res.frame_last   = r_meta[6][0];

endmodule
